// ----- sv/lpi_pkg.sv -----
// Shared types and constants for the 3D line pair closest point block.
package lpi_pkg;

  // Quotient bits resolved by the divider; offsets are clamped at 2^(QB-1).
  localparam int QB = 41;
  // Width of the scaled numerator |N| * |d1_i|.
  localparam int PW = 97;
  // Width of the denominator |c|^2.
  localparam int DW = 64;
  // Divider depth: load stage, one stage per quotient bit, round stage.
  localparam int DIV_LAT = QB + 2;
  // Largest offset magnitude that is passed on unclamped.
  localparam logic [QB-1:0] QCLAMP = {1'b1, {(QB - 1){1'b0}}};

  // One line pair.
  typedef struct packed {
    logic signed [31:0] first_base_x;
    logic signed [31:0] first_base_y;
    logic signed [31:0] first_base_z;
    logic signed [15:0] first_dir_x;
    logic signed [15:0] first_dir_y;
    logic signed [15:0] first_dir_z;
    logic signed [31:0] second_base_x;
    logic signed [31:0] second_base_y;
    logic signed [31:0] second_base_z;
    logic signed [15:0] second_dir_x;
    logic signed [15:0] second_dir_y;
    logic signed [15:0] second_dir_z;
  } line_pair_t;

  // One result point.
  typedef struct packed {
    logic signed [31:0] meet_x;
    logic signed [31:0] meet_y;
    logic signed [31:0] meet_z;
    logic               parallel_flag;
    logic               overflow_flag;
  } meet_t;

  // Per item values that travel beside the divider.
  typedef struct packed {
    logic [2:0][31:0] p1;
    logic [2:0]       d1neg;
    logic             nneg;
    logic             par;
  } side_t;

endpackage

// ----- sv/line_pair_intersection_3d.sv -----
// Top level of the 3D line pair closest point block.
// Each transaction on the line channel carries two lines, a base point in
// Q16.16 and a direction in Q2.14 for each. Each returns one transaction on
// the meet channel: the point on line 1 closest to line 2 in Q16.16, with a
// parallel flag (cross product of the directions is zero, point reads zero)
// and an overflow flag (a coordinate was saturated).
// The path is 54 register stages: 10 stages of cross products and
// numerator/denominator assembly, 43 stages of divider (load, one quotient
// bit per stage over 41 stages, round) and one output stage. The first stage
// captures at the accepting edge. Throughput is one transaction per cycle
// while line_stall is low; the bit-per-stage divider pipeline sets the depth.
// The whole pipeline advances together. While meet_valid is high and
// meet_stall is high, every stage holds and line_stall is raised; bubbles
// are not squeezed out during a stall.
// Reset clears all valid bits; data registers are not reset.
module line_pair_intersection_3d (
  input  logic                clk,
  input  logic                rst,
  input  logic                line_valid,
  output logic                line_stall,
  input  lpi_pkg::line_pair_t line,
  output logic                meet_valid,
  input  logic                meet_stall,
  output lpi_pkg::meet_t      meet
);

  localparam int QB = lpi_pkg::QB;
  localparam int DL = lpi_pkg::DIV_LAT;

  logic adv;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv        = !meet_valid || !meet_stall;
  assign line_stall = !adv;

  logic                        f_valid;
  logic [2:0][lpi_pkg::PW-1:0] f_prod;
  logic [lpi_pkg::DW-1:0]      f_den;
  lpi_pkg::side_t              f_side;
  logic [2:0][QB-1:0]          qm;

  lpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid     (line_valid),
    .line      (line),
    .out_valid (f_valid),
    .prod      (f_prod),
    .den       (f_den),
    .side      (f_side)
  );

  lpi_div u_div (
    .clk  (clk),
    .adv  (adv),
    .prod (f_prod),
    .den  (f_den),
    .qm   (qm)
  );

  // Side values and valid bits travel beside the divider.
  lpi_pkg::side_t sd [0:DL-1];
  logic [DL-1:0]  dv;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= f_side;
      for (int k = 1; k < DL; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (adv) begin
      dv <= {dv[DL-2:0], f_valid};
    end
  end

  // Apply the signed offset to p1 and saturate each coordinate.
  logic signed [42:0] val  [3];
  logic signed [31:0] crd  [3];
  logic               sclp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd[DL-1].nneg ^ sd[DL-1].d1neg[i]) begin
        val[i] = 43'($signed(sd[DL-1].p1[i])) - $signed(43'(qm[i]));
      end else begin
        val[i] = 43'($signed(sd[DL-1].p1[i])) + $signed(43'(qm[i]));
      end
      if (val[i] > 43'sh0_7FFF_FFFF) begin
        crd[i]  = 32'sh7FFF_FFFF;
        sclp[i] = 1'b1;
      end else if (val[i] < -43'sh0_8000_0000) begin
        crd[i]  = 32'sh8000_0000;
        sclp[i] = 1'b1;
      end else begin
        crd[i]  = val[i][31:0];
        sclp[i] = 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      meet_valid <= 1'b0;
    end else if (adv) begin
      meet_valid <= dv[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sd[DL-1].par) begin
        meet.meet_x        <= '0;
        meet.meet_y        <= '0;
        meet.meet_z        <= '0;
        meet.parallel_flag <= 1'b1;
        meet.overflow_flag <= 1'b0;
      end else begin
        meet.meet_x        <= crd[0];
        meet.meet_y        <= crd[1];
        meet.meet_z        <= crd[2];
        meet.parallel_flag <= 1'b0;
        meet.overflow_flag <= sclp[0] || sclp[1] || sclp[2];
      end
    end
  end

`ifndef SYNTHESIS
  // A parallel result carries a zero point and no overflow.
  a_par_zero: assert property (@(posedge clk) disable iff (rst)
    meet_valid && meet.parallel_flag |->
      meet.meet_x == 32'sd0 && meet.meet_y == 32'sd0 && meet.meet_z == 32'sd0
      && !meet.overflow_flag)
    else $error("parallel result with nonzero point or overflow");

  // Overflow means at least one coordinate sits on a range limit.
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    meet_valid && meet.overflow_flag |->
      meet.meet_x == 32'sh7FFF_FFFF || meet.meet_x == 32'sh8000_0000 ||
      meet.meet_y == 32'sh7FFF_FFFF || meet.meet_y == 32'sh8000_0000 ||
      meet.meet_z == 32'sh7FFF_FFFF || meet.meet_z == 32'sh8000_0000)
    else $error("overflow flagged with no saturated coordinate");

  // A result waiting at the end of the divider is loaded into the output register on an advance.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    adv && dv[DL-1] |=> meet_valid)
    else $error("result lost between divider and output register");
`endif

endmodule

// ----- sv/lpi_front.sv -----
// Front pipeline: cross products, numerator, denominator and scaled numerators.
module lpi_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               valid,
  input  lpi_pkg::line_pair_t                line,
  output logic                               out_valid,
  output logic [2:0][lpi_pkg::PW-1:0]        prod,
  output logic [lpi_pkg::DW-1:0]             den,
  output lpi_pkg::side_t                     side
);

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic signed [31:0] ip1 [3];
  logic signed [31:0] ip2 [3];
  logic signed [15:0] id1 [3];
  logic signed [15:0] id2 [3];

  assign ip1[0] = line.first_base_x;
  assign ip1[1] = line.first_base_y;
  assign ip1[2] = line.first_base_z;
  assign ip2[0] = line.second_base_x;
  assign ip2[1] = line.second_base_y;
  assign ip2[2] = line.second_base_z;
  assign id1[0] = line.first_dir_x;
  assign id1[1] = line.first_dir_y;
  assign id1[2] = line.first_dir_z;
  assign id2[0] = line.second_dir_x;
  assign id2[1] = line.second_dir_y;
  assign id2[2] = line.second_dir_z;

  // Valid bits, one per stage.
  logic [9:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[8:0], valid};
    end
  end

  assign out_valid = vld[9];

  // Base point and direction of line 1 ride along.
  logic [2:0][31:0] cp1 [1:9];
  logic [2:0][15:0] cd1 [1:7];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cp1[1][i] <= ip1[i];
        cd1[1][i] <= id1[i];
      end
      for (int k = 2; k <= 9; k++) begin
        cp1[k] <= cp1[k-1];
      end
      for (int k = 2; k <= 7; k++) begin
        cd1[k] <= cd1[k-1];
      end
    end
  end

  // Stage 1: w = p1 - p2 and the products of d1 x d2.
  logic signed [32:0] s1_w  [3];
  logic signed [31:0] s1_ca [3];
  logic signed [31:0] s1_cb [3];
  logic signed [15:0] s1_d2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_w[i]  <= 33'(ip1[i]) - 33'(ip2[i]);
        s1_ca[i] <= 32'(id1[NXT[i]]) * 32'(id2[PRV[i]]);
        s1_cb[i] <= 32'(id1[PRV[i]]) * 32'(id2[NXT[i]]);
        s1_d2[i] <= id2[i];
      end
    end
  end

  // Stage 2: c = d1 x d2 and the products of d2 x w.
  logic signed [32:0] s2_c  [3];
  logic signed [48:0] s2_ea [3];
  logic signed [48:0] s2_eb [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_c[i]  <= 33'(s1_ca[i]) - 33'(s1_cb[i]);
        s2_ea[i] <= 49'(s1_d2[NXT[i]]) * 49'(s1_w[PRV[i]]);
        s2_eb[i] <= 49'(s1_d2[PRV[i]]) * 49'(s1_w[NXT[i]]);
      end
    end
  end

  // Stage 3: e = d2 x w, magnitudes of c and the parallel test.
  logic signed [49:0] s3_e    [3];
  logic        [31:0] s3_cm   [3];
  logic               s3_cneg [3];
  logic               s3_par;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_e[i]    <= 50'(s2_ea[i]) - 50'(s2_eb[i]);
        s3_cm[i]   <= s2_c[i][32] ? 32'(-s2_c[i]) : 32'(s2_c[i]);
        s3_cneg[i] <= s2_c[i][32];
      end
      s3_par <= (s2_c[0] == 33'sd0) && (s2_c[1] == 33'sd0) && (s2_c[2] == 33'sd0);
    end
  end

  // Stage 4: magnitudes of e and the squares of c.
  logic [48:0] s4_em   [3];
  logic        s4_eneg [3];
  logic [31:0] s4_cm   [3];
  logic        s4_cneg [3];
  logic [63:0] s4_csq  [3];
  logic        s4_par;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_em[i]   <= s3_e[i][49] ? 49'(-s3_e[i]) : 49'(s3_e[i]);
        s4_eneg[i] <= s3_e[i][49];
        s4_cm[i]   <= s3_cm[i];
        s4_cneg[i] <= s3_cneg[i];
        s4_csq[i]  <= s3_cm[i] * s3_cm[i];
      end
      s4_par <= s3_par;
    end
  end

  // Stage 5: split partial products of e . c and the denominator sum.
  logic [56:0] s5_pl [3];
  logic [55:0] s5_ph [3];
  logic        s5_sg [3];
  logic [63:0] s5_den;
  logic        s5_par;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_pl[i] <= s4_em[i][24:0] * s4_cm[i];
        s5_ph[i] <= s4_em[i][48:25] * s4_cm[i];
        s5_sg[i] <= s4_eneg[i] ^ s4_cneg[i];
      end
      s5_den <= s4_csq[0] + s4_csq[1] + s4_csq[2];
      s5_par <= s4_par;
    end
  end

  // Stage 6: signed terms e_i * c_i.
  logic [81:0] t6m [3];
  logic [81:0] s6_t [3];
  logic [63:0] s6_den;
  logic        s6_par;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t6m[i] = 82'({s5_ph[i], 25'b0}) + 82'(s5_pl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s6_t[i] <= s5_sg[i] ? -t6m[i] : t6m[i];
      end
      s6_den <= s5_den;
      s6_par <= s5_par;
    end
  end

  // Stage 7: numerator N = (d2 x w) . c.
  logic [81:0] s7_num;
  logic [63:0] s7_den;
  logic        s7_par;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_num <= s6_t[0] + s6_t[1] + s6_t[2];
      s7_den <= s6_den;
      s7_par <= s6_par;
    end
  end

  // Stage 8: sign and magnitude of N and of d1.
  logic        s8_nneg;
  logic [80:0] s8_nmag;
  logic [15:0] s8_dm [3];
  logic [2:0]  s8_d1neg;
  logic [63:0] s8_den;
  logic        s8_par;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_nneg <= s7_num[81];
      s8_nmag <= s7_num[81] ? 81'(-s7_num) : 81'(s7_num);
      for (int i = 0; i < 3; i++) begin
        s8_dm[i]    <= cd1[7][i][15] ? -cd1[7][i] : cd1[7][i];
        s8_d1neg[i] <= cd1[7][i][15];
      end
      s8_den <= s7_den;
      s8_par <= s7_par;
    end
  end

  // Stage 9: partial products of |N| * |d1_i|, three 27 bit slices.
  logic [42:0] s9_mp [3][3];
  logic        s9_nneg;
  logic [2:0]  s9_d1neg;
  logic [63:0] s9_den;
  logic        s9_par;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s9_mp[i][j] <= s8_nmag[27*j +: 27] * s8_dm[i];
        end
      end
      s9_nneg  <= s8_nneg;
      s9_d1neg <= s8_d1neg;
      s9_den   <= s8_den;
      s9_par   <= s8_par;
    end
  end

  // Stage 10: assemble the scaled numerators.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= 97'({s9_mp[i][2], 54'b0}) + 97'({s9_mp[i][1], 27'b0})
                   + 97'(s9_mp[i][0]);
      end
      den        <= s9_den;
      side.p1    <= cp1[9];
      side.d1neg <= s9_d1neg;
      side.nneg  <= s9_nneg;
      side.par   <= s9_par;
    end
  end

endmodule

// ----- sv/lpi_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, with rounding and clamp.
module lpi_div (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [2:0][lpi_pkg::PW-1:0]    prod,
  input  logic [lpi_pkg::DW-1:0]         den,
  output logic [2:0][lpi_pkg::QB-1:0]    qm
);

  localparam int QB = lpi_pkg::QB;
  localparam int PW = lpi_pkg::PW;
  localparam int DW = lpi_pkg::DW;

  logic [DW-1:0] dd  [0:QB];
  logic [DW-1:0] rr  [0:QB][3];
  logic [QB-1:0] lo  [0:QB-1][3];
  logic [QB-1:0] qq  [0:QB][3];
  logic          sat [0:QB][3];

  // Load stage: a high part at or above the divisor means a quotient past the clamp.
  always_ff @(posedge clk) begin
    if (adv) begin
      dd[0] <= den;
      for (int i = 0; i < 3; i++) begin
        sat[0][i] <= DW'(prod[i][PW-1:QB]) >= den;
        rr[0][i]  <= DW'(prod[i][PW-1:QB]);
        lo[0][i]  <= prod[i][QB-1:0];
        qq[0][i]  <= '0;
      end
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [DW:0] tt [3];
    logic        ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tt[i] = {rr[k-1][i], lo[k-1][i][QB-k]};
        ge[i] = tt[i] >= {1'b0, dd[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dd[k] <= dd[k-1];
        for (int i = 0; i < 3; i++) begin
          rr[k][i]  <= ge[i] ? DW'(tt[i] - {1'b0, dd[k-1]}) : tt[i][DW-1:0];
          qq[k][i]  <= qq[k-1][i] | (QB'(ge[i]) << (QB - k));
          sat[k][i] <= sat[k-1][i];
        end
      end
    end

    if (k < QB) begin : g_lo
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 3; i++) begin
            lo[k][i] <= lo[k-1][i];
          end
        end
      end
    end
  end

  // Round half away from zero on the magnitude, then clamp.
  logic        up [3];
  logic [QB:0] qr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up[i] = {rr[QB][i], 1'b0} >= {1'b0, dd[QB]};
      qr[i] = (QB + 1)'(qq[QB][i]) + (QB + 1)'(up[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (sat[QB][i] || (qr[i] > (QB + 1)'(lpi_pkg::QCLAMP))) begin
          qm[i] <= lpi_pkg::QCLAMP;
        end else begin
          qm[i] <= qr[i][QB-1:0];
        end
      end
    end
  end

endmodule
